[src/pbwt_pkg.sv]
// Shared constants, codes and transaction types for the PBWT sort and divergence update block.
package pbwt_pkg;

  localparam int MAX_HAPS  = 1024;
  localparam int HAP_W     = $clog2(MAX_HAPS);
  localparam int CNT_W     = HAP_W + 1;
  localparam int SITE_BITS = 16;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // Transaction kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_RESTART = 2'd3;

  // Register indexes (paddr[2])
  localparam logic REG_NUM_HAPS  = 1'b0;
  localparam logic REG_NUM_SITES = 1'b1;

  localparam logic [CNT_W-1:0]     NUM_HAPS_RST  = CNT_W'(MAX_HAPS);
  localparam logic [SITE_BITS-1:0] NUM_SITES_RST = '1;

  typedef struct packed {
    logic [1:0]           kind;
    logic [9:0]           hap_index;
    logic                 allele;
    logic [15:0]          site_pos;
    logic [9:0]           position;
  } pbwt_in_t;

  typedef struct packed {
    logic [9:0]  order_hap;
    logic [15:0] divergence;
    logic [10:0] zero_count;
  } pbwt_out_t;

  typedef struct packed {
    logic [10:0] num_haps;
    logic [15:0] num_sites;
  } cfg_t;

  // One entry of the order/divergence arrays
  typedef struct packed {
    logic [HAP_W-1:0]     hap;
    logic [SITE_BITS-1:0] div;
  } ent_t;

  typedef struct packed {
    logic             we;
    logic [HAP_W-1:0] waddr;
    ent_t             wdata;
    logic [HAP_W-1:0] raddr;
  } ent_port_t;

  typedef struct packed {
    logic             we;
    logic [HAP_W-1:0] waddr;
    logic             wdata;
    logic [HAP_W-1:0] raddr;
  } bit_port_t;

endpackage

[src/pbwt_sort_and_divergence_update_top.sv]
// Top level of the PBWT sort and divergence update block.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (pbwt_in_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (pbwt_out_t)
//  cfg     | input     | psel/penable/pwrite    | paddr/pwdata, prdata, pready
//
//  Timing: an advance walks the N active entries of the order memory, one entry per cycle
//  through its single read port, then appends the allele-1 group. A restart rewrites
//  all 1024 entries, one per cycle, then emits.
//  Reset: a clearing pass writes identity order and divergence 65535;
//  no transaction is taken until it ends, register writes are taken throughout.
//  Stalls: the result register holds a finished transaction while the next one runs;
//  only the emit step waits on out_stall_i.
module pbwt_sort_and_divergence_update_top import pbwt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pbwt_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pbwt_out_t         out_data_o
);

  cfg_t                cfg;
  ent_port_t           ord_port;
  ent_port_t           ones_port;
  bit_port_t           al_port;
  logic [$bits(ent_t)-1:0] ord_rdata_raw;
  logic [$bits(ent_t)-1:0] ones_rdata_raw;
  logic                al_rdata;

  pbwt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sorted order and divergence, one entry per sorted position
  pbwt_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_HAPS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_port.we),
    .waddr_i (ord_port.waddr),
    .wdata_i (ord_port.wdata),
    .raddr_i (ord_port.raddr),
    .rdata_o (ord_rdata_raw)
  );

  // Scratch for the allele-1 group during an advance
  pbwt_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_HAPS)) u_ones_ram (
    .clk_i   (clk_i),
    .we_i    (ones_port.we),
    .waddr_i (ones_port.waddr),
    .wdata_i (ones_port.wdata),
    .raddr_i (ones_port.raddr),
    .rdata_o (ones_rdata_raw)
  );

  // Allele column of the current site, indexed by haplotype
  pbwt_ram #(.WIDTH(1), .DEPTH(MAX_HAPS)) u_al_ram (
    .clk_i   (clk_i),
    .we_i    (al_port.we),
    .waddr_i (al_port.waddr),
    .wdata_i (al_port.wdata),
    .raddr_i (al_port.raddr),
    .rdata_o (al_rdata)
  );

  pbwt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o),
    .ord_o        (ord_port),
    .ord_rdata_i  (ent_t'(ord_rdata_raw)),
    .ones_o       (ones_port),
    .ones_rdata_i (ent_t'(ones_rdata_raw)),
    .al_o         (al_port),
    .al_rdata_i   (al_rdata)
  );

endmodule

[src/pbwt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module pbwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pbwt_apb_regs.sv]
// APB configuration registers: haplotype count and site count.
module pbwt_apb_regs import pbwt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [10:0] num_haps_q;
  logic [15:0] num_sites_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_haps_q  <= NUM_HAPS_RST;
      num_sites_q <= NUM_SITES_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NUM_HAPS:  num_haps_q  <= pwdata[10:0];
        REG_NUM_SITES: num_sites_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NUM_HAPS:  prdata = APB_DW'(num_haps_q);
      REG_NUM_SITES: prdata = APB_DW'(num_sites_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.num_haps  = num_haps_q;
  assign cfg_o.num_sites = num_sites_q;

endmodule

[src/pbwt_ctrl.sv]
// Sequencer for load, advance, read and restart, with the result register.
module pbwt_ctrl import pbwt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pbwt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pbwt_out_t out_data_o,
  output ent_port_t ord_o,
  input  ent_t      ord_rdata_i,
  output ent_port_t ones_o,
  input  ent_t      ones_rdata_i,
  output bit_port_t al_o,
  input  logic      al_rdata_i
);

  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_P1   = 3'd2;
  localparam logic [2:0] ST_P2   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 v1_q, v1_d;
  logic                 v2_q, v2_d;
  logic [CNT_W-1:0]     zeros_q, zeros_d;
  logic [CNT_W-1:0]     ones_q, ones_d;
  logic [SITE_BITS-1:0] run0_q, run0_d;
  logic [SITE_BITS-1:0] run1_q, run1_d;
  ent_t                 b_ent_q, b_ent_d;
  logic [HAP_W-1:0]     p2_addr_q, p2_addr_d;
  logic [SITE_BITS-1:0] fill_div_q, fill_div_d;
  logic                 fill_emit_q, fill_emit_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [HAP_W-1:0]     res_hap_q, res_hap_d;
  logic [SITE_BITS-1:0] res_div_q, res_div_d;
  logic [CNT_W-1:0]     zc_q, zc_d;
  logic                 out_valid_q, out_valid_d;
  pbwt_out_t            out_q, out_d;

  logic [CNT_W-1:0]     cnt;
  logic                 out_free;
  logic                 out_load;
  logic [SITE_BITS-1:0] m0, m1;

  assign cnt = (cfg_i.num_haps > CNT_W'(MAX_HAPS)) ? CNT_W'(MAX_HAPS) : cfg_i.num_haps;
  assign out_free = !out_valid_q || !out_stall_i;
  assign m0 = (b_ent_q.div < run0_q) ? b_ent_q.div : run0_q;
  assign m1 = (b_ent_q.div < run1_q) ? b_ent_q.div : run1_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    zeros_d     = zeros_q;
    ones_d      = ones_q;
    run0_d      = run0_q;
    run1_d      = run1_q;
    b_ent_d     = b_ent_q;
    p2_addr_d   = p2_addr_q;
    fill_div_d  = fill_div_q;
    fill_emit_d = fill_emit_q;
    rd_ok_d     = rd_ok_q;
    res_hap_d   = res_hap_q;
    res_div_d   = res_div_q;
    zc_d        = zc_q;
    out_load    = 1'b0;

    ord_o        = '0;
    ord_o.raddr  = idx_q[HAP_W-1:0];
    ones_o       = '0;
    ones_o.raddr = idx_q[HAP_W-1:0];
    al_o         = '0;
    al_o.raddr   = ord_rdata_i.hap;

    case (state_q)
      ST_FILL: begin
        ord_o.we        = 1'b1;
        ord_o.waddr     = idx_q[HAP_W-1:0];
        ord_o.wdata.hap = idx_q[HAP_W-1:0];
        ord_o.wdata.div = fill_div_q;
        if (idx_q == CNT_W'(MAX_HAPS - 1)) begin
          idx_d   = '0;
          state_d = fill_emit_q ? ST_EMIT : ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          res_hap_d = '0;
          res_div_d = '0;
          case (in_data_i.kind)
            KIND_LOAD: begin
              al_o.we    = 1'b1;
              al_o.waddr = in_data_i.hap_index;
              al_o.wdata = in_data_i.allele;
              if (out_free) begin
                out_load = 1'b1;
              end else begin
                state_d = ST_EMIT;
              end
            end
            KIND_ADVANCE: begin
              run0_d  = in_data_i.site_pos;
              run1_d  = in_data_i.site_pos;
              zeros_d = '0;
              ones_d  = '0;
              idx_d   = '0;
              state_d = ST_P1;
            end
            KIND_READ: begin
              ord_o.raddr = in_data_i.position;
              rd_ok_d     = ({1'b0, in_data_i.position} < cnt);
              state_d     = ST_RD;
            end
            default: begin
              fill_div_d  = cfg_i.num_sites;
              fill_emit_d = 1'b1;
              zc_d        = '0;
              idx_d       = '0;
              state_d     = ST_FILL;
            end
          endcase
        end
      end

      ST_P1: begin
        // Issue order reads, then allele reads, then partition.
        if (idx_q < cnt) begin
          v1_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
        v2_d    = v1_q;
        b_ent_d = ord_rdata_i;
        if (v2_q) begin
          if (!al_rdata_i) begin
            ord_o.we        = 1'b1;
            ord_o.waddr     = zeros_q[HAP_W-1:0];
            ord_o.wdata.hap = b_ent_q.hap;
            ord_o.wdata.div = m0;
            zeros_d         = zeros_q + 1'b1;
            run0_d          = cfg_i.num_sites;
            run1_d          = m1;
          end else begin
            ones_o.we        = 1'b1;
            ones_o.waddr     = ones_q[HAP_W-1:0];
            ones_o.wdata.hap = b_ent_q.hap;
            ones_o.wdata.div = m1;
            ones_d           = ones_q + 1'b1;
            run1_d           = cfg_i.num_sites;
            run0_d           = m0;
          end
        end
        if (idx_q >= cnt && !v1_q && !v2_q) begin
          idx_d     = '0;
          p2_addr_d = zeros_q[HAP_W-1:0];
          state_d   = ST_P2;
        end
      end

      ST_P2: begin
        // Append the allele-1 group behind the allele-0 group.
        if (idx_q < ones_q) begin
          v1_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
        if (v1_q) begin
          ord_o.we    = 1'b1;
          ord_o.waddr = p2_addr_q;
          ord_o.wdata = ones_rdata_i;
          p2_addr_d   = p2_addr_q + 1'b1;
        end
        if (idx_q >= ones_q && !v1_q) begin
          zc_d    = zeros_q;
          state_d = ST_EMIT;
        end
      end

      ST_RD: begin
        res_hap_d = rd_ok_q ? ord_rdata_i.hap : '0;
        res_div_d = rd_ok_q ? ord_rdata_i.div : '0;
        state_d   = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_d.order_hap  = (state_q == ST_EMIT) ? res_hap_q : '0;
    out_d.divergence = (state_q == ST_EMIT) ? res_div_q : '0;
    out_d.zero_count = zc_q;
    out_valid_d      = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      zeros_q     <= '0;
      ones_q      <= '0;
      fill_div_q  <= NUM_SITES_RST;
      fill_emit_q <= 1'b0;
      zc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      zeros_q     <= zeros_d;
      ones_q      <= ones_d;
      fill_div_q  <= fill_div_d;
      fill_emit_q <= fill_emit_d;
      zc_q        <= zc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run0_q    <= run0_d;
    run1_q    <= run1_d;
    b_ent_q   <= b_ent_d;
    p2_addr_q <= p2_addr_d;
    rd_ok_q   <= rd_ok_d;
    res_hap_q <= res_hap_d;
    res_div_q <= res_div_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Partitioned entries never outrun the entries read.
  a_p1_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1) |->
      (({1'b0, zeros_q} + {1'b0, ones_q}) <= {1'b0, idx_q}))
    else $error("partition wrote more entries than were read");

  // In-place writes stay behind the read pointer.
  a_p1_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1 && ord_o.we) |-> ({1'b0, ord_o.waddr} < idx_q))
    else $error("order write overtook the read pointer");

  // The appended group lands inside the active range.
  a_p2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P2 && ord_o.we) |-> ({1'b0, ord_o.waddr} < cnt))
    else $error("append wrote beyond the active count");

  // A new result only comes from the emit step or a direct load result.
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_IDLE))
    else $error("result appeared outside the emit step");

endmodule

[tb/sv/pbwt_sort_and_divergence_update_top_tb.sv]
// Self-checking testbench for the PBWT sort and divergence update block.
module pbwt_sort_and_divergence_update_top_tb;
  import pbwt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 8;
  // Watchdog on the whole run, which includes the clearing pass, restarts and wide sweeps.
  localparam int RUN_LIMIT    = 2_000_000;
  // Longest single transaction: a full-width advance or a restart, plus output stalls.
  localparam int DRAIN_CYCLES = 6000;
  localparam int TAIL_CYCLES  = 20;
  localparam int IDLE_PCT     = 22;
  localparam int WIDE_HAPS    = 96;
  localparam int PHASE_ITEMS  = 28;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  pbwt_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pbwt_out_t         out_data_o;

  pbwt_sort_and_divergence_update_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block's state: sorted order, divergences, allele column
  // of the current site, last zero count and the two registers.
  // ---------------------------------------------------------------------------
  logic [HAP_W-1:0]     sw_order        [MAX_HAPS];
  logic [SITE_BITS-1:0] sw_div          [MAX_HAPS];
  logic                 sw_allele       [MAX_HAPS];
  logic                 sw_allele_known [MAX_HAPS];
  logic [CNT_W-1:0]     sw_zeros;
  logic [CNT_W-1:0]     cfg_haps;
  logic [SITE_BITS-1:0] cfg_sites;

  // Results predicted at acceptance, oldest first.
  pbwt_out_t    order_results_q [$];
  pbwt_out_t    want;
  int unsigned  err_count  = 0;
  int unsigned  items_sent = 0;
  int unsigned  idle_pct   = IDLE_PCT;
  int unsigned  stall_pct  = IDLE_PCT;

  function automatic int unsigned active_haps();
    return (cfg_haps < MAX_HAPS) ? int'(cfg_haps) : MAX_HAPS;
  endfunction

  // Identity order over every entry, divergence at the site count.
  function automatic void restart_order();
    for (int i = 0; i < MAX_HAPS; i++) begin
      sw_order[i] = HAP_W'(i);
      sw_div[i]   = cfg_sites;
    end
    sw_zeros = '0;
  endfunction

  // Stable partition on the allele column with one running minimum per group.
  function automatic void sort_on_site(logic [SITE_BITS-1:0] site);
    logic [HAP_W-1:0]     one_hap [MAX_HAPS];
    logic [SITE_BITS-1:0] one_div [MAX_HAPS];
    logic [SITE_BITS-1:0] run0, run1, dv;
    logic [HAP_W-1:0]     hap;
    int unsigned          n_haps, zeros, ones;
    n_haps = active_haps();
    zeros  = 0;
    ones   = 0;
    run0   = site;
    run1   = site;
    for (int unsigned i = 0; i < n_haps; i++) begin
      hap = sw_order[i];
      dv  = sw_div[i];
      if (dv < run0) run0 = dv;
      if (dv < run1) run1 = dv;
      if (!sw_allele[hap]) begin
        // zeros never passes i, so the in-place write stays behind the walk
        sw_order[zeros] = hap;
        sw_div[zeros]   = run0;
        zeros++;
        run0 = cfg_sites;
      end else begin
        one_hap[ones] = hap;
        one_div[ones] = run1;
        ones++;
        run1 = cfg_sites;
      end
    end
    for (int unsigned i = 0; i < ones; i++) begin
      sw_order[zeros + i] = one_hap[i];
      sw_div[zeros + i]   = one_div[i];
    end
    sw_zeros = CNT_W'(zeros);
  endfunction

  // Apply one accepted transaction to the shadow state and return its result.
  function automatic pbwt_out_t step_order_state(pbwt_in_t t);
    pbwt_out_t r;
    r = '0;
    case (t.kind)
      KIND_LOAD: begin
        sw_allele[t.hap_index]       = t.allele;
        sw_allele_known[t.hap_index] = 1'b1;
      end
      KIND_ADVANCE: sort_on_site(t.site_pos);
      KIND_READ: begin
        if (t.position < active_haps()) begin
          r.order_hap  = sw_order[t.position];
          r.divergence = sw_div[t.position];
        end
      end
      KIND_RESTART: restart_order();
      default: ;
    endcase
    r.zero_count = sw_zeros;
    return r;
  endfunction

  // Fill every field at random so unused fields toggle too, then fix the kind.
  function automatic pbwt_in_t random_item(logic [1:0] kind);
    pbwt_in_t t;
    t.kind      = kind;
    t.hap_index = 10'($urandom_range(1023));
    t.allele    = 1'($urandom_range(1));
    t.site_pos  = 16'($urandom_range(65535));
    t.position  = 10'($urandom_range(1023));
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, run limit and output-side stalls.
  // ---------------------------------------------------------------------------
  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    #RUN_LIMIT;
    $display("FAIL");
    $finish;
  end

  // Stall the result channel at random; stall_pct drops to 0 for a clean stretch.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (order_results_q.size() == 0) begin
        $error("result with nothing expected: order_hap %0d divergence %0d zero_count %0d",
               out_data_o.order_hap, out_data_o.divergence, out_data_o.zero_count);
        err_count++;
      end else begin
        want = order_results_q.pop_front();
        if (out_data_o.order_hap !== want.order_hap) begin
          $error("order_hap: expected %0d, got %0d", want.order_hap, out_data_o.order_hap);
          err_count++;
        end
        if (out_data_o.divergence !== want.divergence) begin
          $error("divergence: expected %0d, got %0d", want.divergence, out_data_o.divergence);
          err_count++;
        end
        if (out_data_o.zero_count !== want.zero_count) begin
          $error("zero_count: expected %0d, got %0d", want.zero_count, out_data_o.zero_count);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers.
  // ---------------------------------------------------------------------------

  // Send one transaction; valid stays high into the next call unless a gap is drawn,
  // so it is never lowered and raised within one time step.
  task automatic send_item(pbwt_in_t t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    // Hold the payload until the block takes it.
    do @(posedge clk_i); while (in_stall_o);
    order_results_q.push_back(step_order_state(t));
    items_sent++;
  endtask

  // Drop valid and wait for every predicted result to come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (order_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // APB write then read-back of one register; call only while the block is idle.
  task automatic write_reg(logic sel, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // The register takes the value at this edge.
    if (sel == REG_NUM_HAPS) cfg_haps = value[CNT_W-1:0];
    else                     cfg_sites = value[SITE_BITS-1:0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = (sel == REG_NUM_HAPS) ? APB_DW'(cfg_haps) : APB_DW'(cfg_sites);
    if (prdata !== readback) begin
      $error("prdata: expected %0d, got %0d", readback, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    // Let the bus go idle before the next access.
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned haps, int unsigned sites);
    hold_until_drained();
    write_reg(REG_NUM_HAPS, APB_DW'(haps));
    write_reg(REG_NUM_SITES, APB_DW'(sites));
  endtask

  task automatic send_load(int unsigned hap, logic allele);
    pbwt_in_t t;
    t           = random_item(KIND_LOAD);
    t.hap_index = HAP_W'(hap);
    t.allele    = allele;
    send_item(t);
  endtask

  // Load any allele bit an advance would read but that was never written.
  task automatic load_missing_alleles();
    for (int unsigned i = 0; i < active_haps(); i++) begin
      if (!sw_allele_known[sw_order[i]]) send_load(sw_order[i], 1'($urandom_range(1)));
    end
  endtask

  task automatic send_advance(int unsigned site);
    pbwt_in_t t;
    load_missing_alleles();
    t          = random_item(KIND_ADVANCE);
    t.site_pos = SITE_BITS'(site);
    send_item(t);
  endtask

  task automatic send_read(int unsigned pos);
    pbwt_in_t t;
    t          = random_item(KIND_READ);
    t.position = HAP_W'(pos);
    send_item(t);
  endtask

  task automatic send_restart();
    send_item(random_item(KIND_RESTART));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // After reset: identity order, divergence at the reset site count, no zeros.
  task automatic test_reset_state();
    send_read(0);
    send_read(MAX_HAPS - 1);
    send_read($urandom_range(MAX_HAPS - 1));
  endtask

  // Hand-built site on four haplotypes, then a stale-allele advance at the top site.
  task automatic test_small_sort();
    set_config(4, 100);
    send_load(0, 1'b1);
    send_load(1, 1'b0);
    send_load(2, 1'b1);
    send_load(3, 1'b0);
    send_advance(50);
    for (int unsigned p = 0; p < 4; p++) send_read(p);
    // past the active count: zeros come back
    send_read(4);
    // only one bit changes, the rest persist from the last site
    send_load(1, 1'b1);
    send_advance(16'hFFFF);
    send_read(0);
    send_read(3);
  endtask

  // Zero and one active haplotypes.
  task automatic test_tiny_counts();
    set_config(0, 100);
    send_advance(20);
    send_read(0);
    set_config(1, 100);
    send_advance(10);
    send_read(0);
    send_read(1);
  endtask

  // Restart at a site count of one, then reads under an oversized count clamped to the array.
  task automatic test_restart();
    set_config(2047, 1);
    send_restart();
    send_read(2);
    send_read(MAX_HAPS - 1);
  endtask

  // Wide sweep: every active haplotype loaded, a few advances, then a smaller count.
  task automatic test_wide_sweep();
    set_config(WIDE_HAPS, 16'hFFFF);
    send_restart();
    for (int unsigned h = 0; h < WIDE_HAPS; h++) send_load(h, 1'($urandom_range(1)));
    send_advance(60000);
    send_read(0);
    send_read(WIDE_HAPS - 1);
    repeat (16) send_load($urandom_range(WIDE_HAPS - 1), 1'($urandom_range(1)));
    send_advance(30000);
    send_read($urandom_range(WIDE_HAPS - 1));
    set_config(WIDE_HAPS / 2, 5000);
    send_advance(100);
    send_read(0);
    // past the active count
    send_read(WIDE_HAPS - 1);
    send_read($urandom_range(WIDE_HAPS / 2 - 1));
  endtask

  // Random phases over several register settings. Most traffic is load-advance-read
  // rounds with random content; the rest is loose transactions of every kind.
  task automatic test_random_sweeps();
    int unsigned phase_haps  [8] = '{2, 5, 16, 3, 33, 1, 9, 0};
    int unsigned phase_sites [8] = '{65535, 0, 1, 300, 9999, 40, 65535, 2};
    int unsigned phase_end, n_act, site;
    for (int ph = 0; ph < 8; ph++) begin
      // Pause until all results are back, then reprogram.
      set_config(phase_haps[ph], phase_sites[ph]);
      if (ph == 3) begin
        // clean stretch: no gaps on either side
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        n_act = active_haps();
        site  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(cfg_sites);
        if ($urandom_range(99) < 75) begin
          for (int unsigned i = 0; i < n_act; i++) begin
            if ($urandom_range(99) < 70) send_load(sw_order[i], 1'($urandom_range(1)));
          end
          send_advance(site);
          repeat ($urandom_range(1, 4)) begin
            if (n_act != 0 && $urandom_range(99) < 85) send_read($urandom_range(n_act - 1));
            else                                       send_read($urandom_range(MAX_HAPS - 1));
          end
        end else begin
          case ($urandom_range(9))
            0:       send_restart();
            1, 2, 3: send_item(random_item(KIND_LOAD));
            4, 5, 6: send_item(random_item(KIND_READ));
            default: send_advance(site);
          endcase
        end
      end
    end
    idle_pct  = IDLE_PCT;
    stall_pct = IDLE_PCT;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tests, wide sweep, random sweeps, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned guard;
    cfg_haps  = NUM_HAPS_RST;
    cfg_sites = NUM_SITES_RST;
    for (int i = 0; i < MAX_HAPS; i++) begin
      sw_allele[i]       = 1'b0;
      sw_allele_known[i] = 1'b0;
    end
    restart_order();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_small_sort();
    test_tiny_counts();
    test_restart();
    test_wide_sweep();
    test_random_sweeps();

    // Drain, bounded, then let the tail cycles catch any extra result.
    in_valid_i <= 1'b0;
    guard = 0;
    while (order_results_q.size() != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (order_results_q.size() != 0) begin
      $error("%0d expected results never arrived", order_results_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
